FILE: rtl/core/nd_pkg.sv
// Package of the nutrient dosing controller: widths, register map, reset values and types.
package nd_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int NOW_WIDTH  = 32;
    localparam int PPM_WIDTH  = 16;
    localparam int CNT_WIDTH  = 8;
    localparam int DUR_WIDTH  = 32;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int CFG_IDX_WIDTH  = 3;

    typedef logic [TIME_WIDTH-1:0]     t_time;
    typedef logic [NOW_WIDTH-1:0]      t_now;
    typedef logic [PPM_WIDTH-1:0]      t_ppm;
    typedef logic [CNT_WIDTH-1:0]      t_cnt;
    typedef logic [DUR_WIDTH-1:0]      t_dur;
    typedef logic [CFG_DATA_WIDTH-1:0] t_cfg_data;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_PPM_LOW        = 3'd0,
        REG_PPM_HIGH       = 3'd1,
        REG_TRIGGER_COUNT  = 3'd2,
        REG_PUMP_DURATION  = 3'd3,
        REG_LOCKOUT        = 3'd4,
        REG_CIRCULATION    = 3'd5
    } t_cfg_idx;

    localparam t_cnt COUNT_MAX = t_cnt'(255);

    localparam t_ppm RST_PPM_LOW       = t_ppm'(10);
    localparam t_ppm RST_PPM_HIGH      = t_ppm'(950);
    localparam t_cnt RST_TRIGGER_COUNT = t_cnt'(5);
    localparam t_dur RST_PUMP_DURATION = t_dur'(5 * 200);
    localparam t_dur RST_LOCKOUT       = t_dur'(30 * 1000);
    localparam t_dur RST_CIRCULATION   = t_dur'(10 * 1000);

    typedef struct packed {
        t_ppm ppm_low;
        t_ppm ppm_high;
        t_cnt trigger_count;
        t_dur pump_duration_ms;
        t_dur lockout_ms;
        t_dur circulation_ms;
    } t_cfg;

    typedef struct packed {
        t_now now_ms;
        t_ppm ppm;
        logic circulating;
    } t_poll;

    typedef struct packed {
        logic pump_on;
        logic dose_started;
        logic circulation_request;
    } t_result;

endpackage

FILE: rtl/core/nd_if.sv
// Channel interfaces of the nutrient dosing controller: poll, result and configuration write.
interface nd_in_if;
    logic            valid;
    logic            ready;
    nd_pkg::t_now    now_ms;
    nd_pkg::t_ppm    ppm;
    logic            circulating;

    modport source (output valid, output now_ms, output ppm, output circulating, input ready);
    modport sink   (input valid, input now_ms, input ppm, input circulating, output ready);
endinterface

interface nd_out_if;
    logic valid;
    logic ready;
    logic pump_on;
    logic dose_started;
    logic circulation_request;

    modport source (output valid, output pump_on, output dose_started,
                    output circulation_request, input ready);
    modport sink   (input valid, input pump_on, input dose_started,
                    input circulation_request, output ready);
endinterface

interface nd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [nd_pkg::CFG_IDX_WIDTH-1:0]    index;
    nd_pkg::t_cfg_data                   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/nd_cfg_regs.sv
// Configuration register file of the nutrient dosing controller.
module nd_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr,
    input  logic [nd_pkg::CFG_IDX_WIDTH-1:0] i_idx,
    input  nd_pkg::t_cfg_data                i_data,
    output nd_pkg::t_cfg                     o_cfg
);

    nd_pkg::t_cfg r_cfg;
    nd_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (nd_pkg::t_cfg_idx'(i_idx))
                nd_pkg::REG_PPM_LOW:       n_cfg.ppm_low          = i_data[nd_pkg::PPM_WIDTH-1:0];
                nd_pkg::REG_PPM_HIGH:      n_cfg.ppm_high         = i_data[nd_pkg::PPM_WIDTH-1:0];
                nd_pkg::REG_TRIGGER_COUNT: n_cfg.trigger_count    = i_data[nd_pkg::CNT_WIDTH-1:0];
                nd_pkg::REG_PUMP_DURATION: n_cfg.pump_duration_ms = i_data[nd_pkg::DUR_WIDTH-1:0];
                nd_pkg::REG_LOCKOUT:       n_cfg.lockout_ms       = i_data[nd_pkg::DUR_WIDTH-1:0];
                nd_pkg::REG_CIRCULATION:   n_cfg.circulation_ms   = i_data[nd_pkg::DUR_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ppm_low          <= nd_pkg::RST_PPM_LOW;
            r_cfg.ppm_high         <= nd_pkg::RST_PPM_HIGH;
            r_cfg.trigger_count    <= nd_pkg::RST_TRIGGER_COUNT;
            r_cfg.pump_duration_ms <= nd_pkg::RST_PUMP_DURATION;
            r_cfg.lockout_ms       <= nd_pkg::RST_LOCKOUT;
            r_cfg.circulation_ms   <= nd_pkg::RST_CIRCULATION;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/nd_dose_core.sv
// Dosing state and per-poll decision logic: deadlines, lockout, in-range count.
module nd_dose_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  nd_pkg::t_poll   i_poll,
    input  nd_pkg::t_cfg    i_cfg,
    output nd_pkg::t_result o_res
);

    nd_pkg::t_time r_pump_dl;
    nd_pkg::t_time r_lock_dl;
    nd_pkg::t_cnt  r_cnt;
    logic          r_pump_run;
    logic          r_lock_act;

    nd_pkg::t_time n_pump_dl;
    nd_pkg::t_time n_lock_dl;
    nd_pkg::t_cnt  n_cnt;
    logic          n_pump_run;
    logic          n_lock_act;

    nd_pkg::t_time now;
    nd_pkg::t_cnt  cnt_inc;
    logic          in_range;
    logic          dose;

    assign now      = nd_pkg::t_time'(i_poll.now_ms);
    assign cnt_inc  = r_cnt + nd_pkg::t_cnt'(1);
    assign in_range = (i_poll.ppm > i_cfg.ppm_low) && (i_poll.ppm < i_cfg.ppm_high);

    always_comb begin
        n_pump_dl  = r_pump_dl;
        n_lock_dl  = r_lock_dl;
        n_cnt      = r_cnt;
        n_pump_run = r_pump_run;
        n_lock_act = r_lock_act;
        dose       = 1'b0;

        if (r_pump_run && (now >= r_pump_dl)) begin
            n_pump_run = 1'b0;
        end

        if (!i_poll.circulating) begin
            if (r_lock_act && (now >= r_lock_dl)) begin
                n_lock_act = 1'b0;
            end
            if (!n_lock_act) begin
                if (in_range) begin
                    if (r_cnt != nd_pkg::COUNT_MAX) begin
                        n_cnt = cnt_inc;
                        dose  = (cnt_inc == i_cfg.trigger_count);
                    end
                end else begin
                    n_cnt = '0;
                end
            end
        end

        if (dose) begin
            n_pump_run = 1'b1;
            n_pump_dl  = now + nd_pkg::t_time'(i_cfg.pump_duration_ms);
            n_lock_act = 1'b1;
            n_lock_dl  = now + nd_pkg::t_time'(i_cfg.lockout_ms);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pump_dl  <= '0;
            r_lock_dl  <= '0;
            r_cnt      <= '0;
            r_pump_run <= 1'b0;
            r_lock_act <= 1'b0;
        end else if (i_adv) begin
            r_pump_dl  <= n_pump_dl;
            r_lock_dl  <= n_lock_dl;
            r_cnt      <= n_cnt;
            r_pump_run <= n_pump_run;
            r_lock_act <= n_lock_act;
        end
    end

    assign o_res.pump_on             = n_pump_run;
    assign o_res.dose_started        = dose;
    assign o_res.circulation_request = dose;

endmodule

FILE: rtl/core/nutrient_dosing_controller.sv
// Top level of the nutrient dosing controller.
// Usage:
//   i_in  : one poll per transfer (now_ms, ppm, circulating).
//   o_out : one result per poll (pump_on, dose_started, circulation_request),
//           in poll order.
//   i_cfg : register writes (index, data); ready is always high. Write only
//           while no poll is in flight. Unknown indexes are ignored.
//   circulation_ms is only held here; the circulation pump reads it when it
//   sees circulation_request.
// Pipeline: a transferred poll passes the input register, then the result
//   register, before its result shows on o_out.
// Throughput: one poll per cycle while o_out.ready stays high; the state update is a single pass of
//   compares, one add per deadline and a counter increment.
// Reset: registers return to their reset values, pump off, no lockout,
//   count zero, both pipeline stages empty.
// Stall: while o_out.ready is low a full result register holds; the input
//   register still takes one more poll, then i_in.ready drops.
module nutrient_dosing_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    nd_in_if.sink          i_in,
    nd_out_if.source       o_out,
    nd_cfg_if.sink         i_cfg
);

    nd_pkg::t_cfg    cfg;
    nd_pkg::t_result res;

    logic            r_s1_vld;
    nd_pkg::t_poll   r_s1;
    logic            r_out_vld;
    nd_pkg::t_result r_out;

    logic            s1_adv;
    logic            in_xfer;

    assign s1_adv     = r_s1_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_s1_vld || s1_adv;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    nd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_idx   (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    nd_dose_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (s1_adv),
        .i_poll  (r_s1),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_xfer) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1.now_ms      <= i_in.now_ms;
            r_s1.ppm         <= i_in.ppm;
            r_s1.circulating <= i_in.circulating;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= res;
        end
    end

    assign o_out.valid               = r_out_vld;
    assign o_out.pump_on             = r_out.pump_on;
    assign o_out.dose_started        = r_out.dose_started;
    assign o_out.circulation_request = r_out.circulation_request;

    a_dose_drives_pump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.dose_started) |-> r_out.pump_on)
        else $error("dose started without pump on");

    a_request_matches_dose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.circulation_request == r_out.dose_started))
        else $error("circulation request differs from dose flag");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !r_out_vld) |=> r_out_vld)
        else $error("poll stuck in input register with empty result register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_out.ready) |=> (r_out_vld && $stable(r_out)))
        else $error("stalled result lost or changed");

endmodule

FILE: tb/nutrient_dosing_controller_test.sv
// Self-checking testbench of the nutrient dosing controller: directed and random polls.
`timescale 1ns / 100ps

module nutrient_dosing_controller_test;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASES         = 8;
    localparam logic [nd_pkg::CFG_IDX_WIDTH-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [nd_pkg::CFG_IDX_WIDTH-1:0] REG_SPARE_7 = 3'd7;

    typedef enum logic {ROW_POLL, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind                        kind;
        logic [nd_pkg::CFG_IDX_WIDTH-1:0] idx;
        nd_pkg::t_cfg_data                value;
        nd_pkg::t_poll                    poll;
        logic                             pinned;
        nd_pkg::t_result                  want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    nd_in_if  poll_ch();
    nd_out_if result_ch();
    nd_cfg_if cfg_ch();

    nutrient_dosing_controller u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (poll_ch),
        .o_out   (result_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // dosing state and register copy
    nd_pkg::t_cfg    ctl;
    nd_pkg::t_time   pump_until;
    nd_pkg::t_time   lock_until;
    nd_pkg::t_cnt    streak;
    logic            pump_live;
    logic            lock_live;
    nd_pkg::t_result predicted_results[$];

    nd_pkg::t_poll   taken_poll;
    nd_pkg::t_result head;
    logic            drv_pinned;
    nd_pkg::t_result drv_want;

    int mismatches      = 0;
    int results_seen    = 0;
    int polls_taken     = 0;
    int doses_seen      = 0;
    int writes_taken    = 0;
    int circ_polls      = 0;
    int saturated_polls = 0;
    int idle_cycles     = 0;
    int snk_wait        = 0;

    bit           hold_request = 1'b0;
    bit           src_idle_on  = 1'b1;
    bit           snk_idle_on  = 1'b1;
    nd_pkg::t_cfg phase_cfg;
    int           in_pct;
    int           circ_pct;
    int           step_max;
    nd_pkg::t_now clock_ms;

    t_stim_row plan[$];

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic nd_pkg::t_dur pick_dur();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return nd_pkg::t_dur'(1);
        if (r == 1) return 32'hFFFF_FFFF;
        return nd_pkg::t_dur'($urandom_range(1, 3000));
    endfunction

    function automatic nd_pkg::t_result dose_step(nd_pkg::t_poll p);
        nd_pkg::t_result r;
        logic            dose;
        dose = 1'b0;
        if (pump_live && p.now_ms >= pump_until) begin
            pump_live  = 1'b0;
            pump_until = '0;
        end
        if (!p.circulating) begin
            if (lock_live && p.now_ms >= lock_until) begin
                lock_live  = 1'b0;
                lock_until = '0;
            end
            if (!lock_live) begin
                if (p.ppm > ctl.ppm_low && p.ppm < ctl.ppm_high) begin
                    if (streak < nd_pkg::COUNT_MAX) begin
                        streak = streak + 1'b1;
                        if (streak == ctl.trigger_count) begin
                            dose = 1'b1;
                        end
                    end else begin
                        saturated_polls++;
                    end
                end else begin
                    streak = '0;
                end
            end
        end
        if (dose) begin
            pump_live  = 1'b1;
            pump_until = nd_pkg::t_time'(p.now_ms) + nd_pkg::t_time'(ctl.pump_duration_ms);
            lock_live  = 1'b1;
            lock_until = nd_pkg::t_time'(p.now_ms) + nd_pkg::t_time'(ctl.lockout_ms);
        end
        r.pump_on             = pump_live;
        r.dose_started        = dose;
        r.circulation_request = dose;
        return r;
    endfunction

    function automatic void check_field(string name, logic got, logic want);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on %s of result %0d: expected %0b, got %0b",
                         name, results_seen, want, got);
            end
        end
    endfunction

    function automatic t_stim_row poll_row(nd_pkg::t_now now_ms, nd_pkg::t_ppm ppm,
                                           logic circ, logic pinned,
                                           nd_pkg::t_result want);
        t_stim_row row;
        row                  = '0;
        row.kind             = ROW_POLL;
        row.poll.now_ms      = now_ms;
        row.poll.ppm         = ppm;
        row.poll.circulating = circ;
        row.pinned           = pinned;
        row.want             = want;
        return row;
    endfunction

    function automatic t_stim_row write_row(logic [nd_pkg::CFG_IDX_WIDTH-1:0] idx,
                                            nd_pkg::t_cfg_data value);
        t_stim_row row;
        row       = '0;
        row.kind  = ROW_WRITE;
        row.idx   = idx;
        row.value = value;
        return row;
    endfunction

    task automatic send_poll(nd_pkg::t_poll p, logic pinned, nd_pkg::t_result want);
        int gap;
        gap = (src_idle_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap > 0) begin
            poll_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        poll_ch.valid       <= 1'b1;
        poll_ch.now_ms      <= p.now_ms;
        poll_ch.ppm         <= p.ppm;
        poll_ch.circulating <= p.circulating;
        drv_pinned          <= pinned;
        drv_want            <= want;
        do @(posedge i_clk); while (!poll_ch.ready);
    endtask

    task automatic write_reg(logic [nd_pkg::CFG_IDX_WIDTH-1:0] idx, nd_pkg::t_cfg_data value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic drain_results();
        poll_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (predicted_results.size() != 0) @(posedge i_clk);
    endtask

    // check results, track writes, predict on every poll transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ctl = {nd_pkg::RST_PPM_LOW, nd_pkg::RST_PPM_HIGH, nd_pkg::RST_TRIGGER_COUNT,
                   nd_pkg::RST_PUMP_DURATION, nd_pkg::RST_LOCKOUT, nd_pkg::RST_CIRCULATION};
            pump_until = '0;
            lock_until = '0;
            streak     = '0;
            pump_live  = 1'b0;
            lock_live  = 1'b0;
            predicted_results.delete();
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                results_seen++;
                if (predicted_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d arrived with no poll pending", results_seen);
                    end
                end else begin
                    head = predicted_results.pop_front();
                    check_field("pump_on", result_ch.pump_on, head.pump_on);
                    check_field("dose_started", result_ch.dose_started, head.dose_started);
                    check_field("circulation_request", result_ch.circulation_request,
                                head.circulation_request);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                writes_taken++;
                case (cfg_ch.index)
                    nd_pkg::REG_PPM_LOW:
                        ctl.ppm_low = cfg_ch.data[nd_pkg::PPM_WIDTH-1:0];
                    nd_pkg::REG_PPM_HIGH:
                        ctl.ppm_high = cfg_ch.data[nd_pkg::PPM_WIDTH-1:0];
                    nd_pkg::REG_TRIGGER_COUNT:
                        ctl.trigger_count = cfg_ch.data[nd_pkg::CNT_WIDTH-1:0];
                    nd_pkg::REG_PUMP_DURATION:
                        ctl.pump_duration_ms = cfg_ch.data[nd_pkg::DUR_WIDTH-1:0];
                    nd_pkg::REG_LOCKOUT:
                        ctl.lockout_ms = cfg_ch.data[nd_pkg::DUR_WIDTH-1:0];
                    nd_pkg::REG_CIRCULATION:
                        ctl.circulation_ms = cfg_ch.data[nd_pkg::DUR_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (poll_ch.valid && poll_ch.ready) begin
                taken_poll.now_ms      = poll_ch.now_ms;
                taken_poll.ppm         = poll_ch.ppm;
                taken_poll.circulating = poll_ch.circulating;
                head = dose_step(taken_poll);
                predicted_results.push_back(drv_pinned ? drv_want : head);
                polls_taken++;
                doses_seen += head.dose_started;
                circ_polls += poll_ch.circulating;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((poll_ch.valid && poll_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (snk_wait > 0) begin
                result_ch.ready <= 1'b0;
                snk_wait--;
            end else begin
                result_ch.ready <= 1'b1;
                if (snk_idle_on && $urandom_range(0, 99) < 25) begin
                    snk_wait = pick_gap();
                end
            end
        end
    end

    initial begin
        nd_pkg::t_poll nxt;
        int            r;
        int            n;
        int            hi;
        bit            last_write;

        i_rst_n             <= 1'b0;
        poll_ch.valid       <= 1'b0;
        poll_ch.now_ms      <= '0;
        poll_ch.ppm         <= '0;
        poll_ch.circulating <= 1'b0;
        drv_pinned          <= 1'b0;
        drv_want            <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;

        // pinned results: {pump_on, dose_started, circulation_request}
        plan.push_back(poll_row(32'd0, 16'd0, 1'b0, 1'b1, 3'b000));
        plan.push_back(poll_row(32'd10, 16'd11, 1'b0, 1'b0, 3'b000));
        plan.push_back(poll_row(32'd20, 16'd949, 1'b0, 1'b0, 3'b000));
        plan.push_back(poll_row(32'd30, 16'd500, 1'b1, 1'b0, 3'b000));
        plan.push_back(poll_row(32'd40, 16'd500, 1'b0, 1'b0, 3'b000));
        plan.push_back(poll_row(32'd50, 16'd500, 1'b0, 1'b0, 3'b000));
        plan.push_back(poll_row(32'd60, 16'd500, 1'b0, 1'b1, 3'b111));
        plan.push_back(poll_row(32'd70, 16'hFFFF, 1'b0, 1'b0, 3'b000));
        plan.push_back(poll_row(32'd1060, 16'd10, 1'b1, 1'b1, 3'b000));
        plan.push_back(poll_row(32'd30060, 16'd10, 1'b0, 1'b0, 3'b000));
        plan.push_back(poll_row(32'd30070, 16'd950, 1'b0, 1'b0, 3'b000));
        plan.push_back(poll_row(32'd30080, 16'd11, 1'b0, 1'b0, 3'b000));
        plan.push_back(write_row(nd_pkg::REG_PPM_LOW, 32'd0));
        plan.push_back(write_row(nd_pkg::REG_PPM_HIGH, 32'hFFFF));
        plan.push_back(write_row(nd_pkg::REG_TRIGGER_COUNT, 32'd1));
        plan.push_back(write_row(nd_pkg::REG_PUMP_DURATION, 32'hFFFF_FFFF));
        plan.push_back(write_row(nd_pkg::REG_LOCKOUT, 32'd1));
        plan.push_back(write_row(nd_pkg::REG_CIRCULATION, 32'hFFFF_FFFF));
        plan.push_back(write_row(REG_SPARE_6, 32'h1234_5678));
        plan.push_back(write_row(REG_SPARE_7, 32'hFFFF_FFFF));
        plan.push_back(poll_row(32'hFFFF_FFFE, 16'd0, 1'b0, 1'b1, 3'b000));
        plan.push_back(poll_row(32'hFFFF_FFFF, 16'd1, 1'b0, 1'b1, 3'b111));
        plan.push_back(poll_row(32'd5, 16'hFFFE, 1'b0, 1'b0, 3'b000));
        plan.push_back(poll_row(32'hFFFF_FFFE, 16'h5555, 1'b1, 1'b1, 3'b000));
        plan.push_back(write_row(nd_pkg::REG_PPM_LOW, 32'hFFFF));
        plan.push_back(write_row(nd_pkg::REG_PPM_HIGH, 32'd0));
        plan.push_back(write_row(nd_pkg::REG_TRIGGER_COUNT, 32'd254));
        plan.push_back(poll_row(32'd0, 16'hAAAA, 1'b0, 1'b1, 3'b000));
        plan.push_back(poll_row(32'h8000_0000, 16'hFFFF, 1'b0, 1'b1, 3'b000));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        last_write = 1'b0;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                if (!last_write) drain_results();
                write_reg(plan[i].idx, plan[i].value);
                last_write = 1'b1;
            end else begin
                if (last_write) cfg_ch.valid <= 1'b0;
                send_poll(plan[i].poll, plan[i].pinned, plan[i].want);
                last_write = 1'b0;
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            if (ph == 0) begin
                // one long in-range run: dose at 254, then the count saturates
                phase_cfg = {16'd0, 16'hFFFF, 8'd254, 32'd500, 32'd50, 32'd10000};
                clock_ms  = 32'hFFFF_F000;
                in_pct    = 100;
                circ_pct  = 0;
                step_max  = 40;
            end else if (ph == PHASES - 1) begin
                phase_cfg = {16'd0, 16'hFFFF, 8'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0};
                in_pct    = 85;
                circ_pct  = 10;
                step_max  = 300;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 15) phase_cfg.ppm_low = nd_pkg::t_ppm'(0);
                else if (r < 20) phase_cfg.ppm_low = 16'hFFFF;
                else phase_cfg.ppm_low = nd_pkg::t_ppm'($urandom_range(0, 300));
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    phase_cfg.ppm_high = 16'hFFFF;
                end else if (r < 15) begin
                    phase_cfg.ppm_high = nd_pkg::t_ppm'($urandom);
                end else begin
                    hi = int'(phase_cfg.ppm_low) + $urandom_range(2, 1500);
                    if (hi > 65535) hi = 65535;
                    phase_cfg.ppm_high = nd_pkg::t_ppm'(hi);
                end
                r = $urandom_range(0, 99);
                if (r < 15) phase_cfg.trigger_count = nd_pkg::t_cnt'(1);
                else if (r < 20) phase_cfg.trigger_count = nd_pkg::t_cnt'(254);
                else phase_cfg.trigger_count = nd_pkg::t_cnt'($urandom_range(2, 8));
                phase_cfg.pump_duration_ms = pick_dur();
                phase_cfg.lockout_ms       = pick_dur();
                phase_cfg.circulation_ms   = $urandom_range(0, 1) ? nd_pkg::t_dur'(0)
                                                                  : nd_pkg::t_dur'($urandom);
                in_pct   = 85;
                circ_pct = 10;
                step_max = $urandom_range(10, 400);
            end
            src_idle_on = (ph % 3 != 1);
            snk_idle_on = (ph % 4 != 2);

            write_reg(nd_pkg::REG_PPM_LOW, nd_pkg::t_cfg_data'(phase_cfg.ppm_low));
            write_reg(nd_pkg::REG_PPM_HIGH, nd_pkg::t_cfg_data'(phase_cfg.ppm_high));
            write_reg(nd_pkg::REG_TRIGGER_COUNT, nd_pkg::t_cfg_data'(phase_cfg.trigger_count));
            write_reg(nd_pkg::REG_PUMP_DURATION,
                      nd_pkg::t_cfg_data'(phase_cfg.pump_duration_ms));
            write_reg(nd_pkg::REG_LOCKOUT, nd_pkg::t_cfg_data'(phase_cfg.lockout_ms));
            write_reg(nd_pkg::REG_CIRCULATION, nd_pkg::t_cfg_data'(phase_cfg.circulation_ms));
            cfg_ch.valid <= 1'b0;

            n = (ph == 0) ? 300 : 220;
            for (int k = 0; k < n; k++) begin
                if (ph == 2 && k == 40) hold_request = 1'b1;
                if (ph == 3 && k == 110) drain_results();
                r = $urandom_range(0, 99);
                if (r < 2) clock_ms = nd_pkg::t_now'($urandom);
                else clock_ms = clock_ms + nd_pkg::t_now'($urandom_range(0, step_max));
                nxt.now_ms      = clock_ms;
                nxt.circulating = ($urandom_range(0, 99) < circ_pct);
                r = $urandom_range(0, 99);
                if (r < in_pct && int'(phase_cfg.ppm_high) - int'(phase_cfg.ppm_low) >= 2) begin
                    nxt.ppm = nd_pkg::t_ppm'($urandom_range(phase_cfg.ppm_low + 1,
                                                            phase_cfg.ppm_high - 1));
                end else if (r < in_pct + 8) begin
                    nxt.ppm = r[0] ? phase_cfg.ppm_low : phase_cfg.ppm_high;
                end else begin
                    nxt.ppm = nd_pkg::t_ppm'($urandom);
                end
                send_poll(nxt, 1'b0, nd_pkg::t_result'(3'b000));
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);

        $display("covered %0d polls (%0d with circulation on), %0d doses, %0d writes",
                 polls_taken, circ_polls, doses_seen, writes_taken);
        $display("in-range count held at its ceiling on %0d polls; %0d mismatches",
                 saturated_polls, mismatches);
        if (mismatches == 0 && predicted_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
